[src/dff_pkg.sv]
`timescale 1ns / 1ps

package dff_pkg;

    localparam int VALUE_W    = 20;
    localparam int DIGITS     = 7;
    localparam int CHAR_W     = 7;
    localparam int COL_W      = 8;
    localparam int ROW_W      = 2;
    localparam int MODE_W     = 4;
    localparam int FIELD_MAX  = 6;
    localparam int POS_W      = 3;
    localparam int DAB_STAGES = 4;
    localparam int DAB_STEPS  = VALUE_W / DAB_STAGES;

    localparam logic [MODE_W-1:0] MODE_DIG2   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_DIG3   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_DIG4   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DIG5   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DIG6   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_ANGLE  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_OFFSET = 4'd6;
    localparam logic [MODE_W-1:0] MODE_DDD_D  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DD_D   = 4'd8;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2b;
    localparam logic [CHAR_W-1:0] CH_POINT = 7'h2e;

    localparam logic [VALUE_W-1:0] ANGLE_CENTER  = 20'd100;
    localparam logic [VALUE_W-1:0] OFFSET_CENTER = 20'h148;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] sign_char;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              inv;
    } side_t;

    typedef logic [DIGITS-1:0][3:0] bcd_t;

    typedef struct packed {
        bcd_t               bcd;
        logic [VALUE_W-1:0] bin;
        side_t              side;
    } dab_t;

    typedef struct packed {
        logic [FIELD_MAX-1:0][CHAR_W-1:0] code;
        logic [FIELD_MAX-1:0]             drawn;
        logic [POS_W-1:0]                 count;
        logic [ROW_W-1:0]                 row;
        logic [COL_W-1:0]                 col;
        logic                             inv;
    } field_t;

endpackage

[src/decimal_field_formatter.sv]
`timescale 1ns / 1ps

// Decimal field formatter: one input word (mode, value, row, start_col, invert)
// becomes a run of two to six ASCII character words on the output channel,
// one per display column, the final one marked by last.
// Both channels are valid/ready; a word moves on an edge with both high.
// The first character passes the magnitude stage, four binary-to-BCD stages,
// the format stage, the character buffer and the output register.
// Throughput: one character per cycle while out_ready is high; input words
// are taken every cycle while the pipeline has room, and back-to-back fields
// leave no gap.
// Words of an unused mode give no characters and are dropped in the pipeline.
// Reset clears every valid bit; no output appears until a word is taken.
// When the receiver holds out_ready low the output word holds, the pipeline
// fills stage by stage and in_ready falls once all stages are occupied.
module decimal_field_formatter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dff_pkg::MODE_W-1:0]  mode,
    input  logic [dff_pkg::VALUE_W-1:0] value,
    input  logic [dff_pkg::ROW_W-1:0]   row,
    input  logic [dff_pkg::COL_W-1:0]   start_col,
    input  logic                        invert,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dff_pkg::CHAR_W-1:0]  char_code,
    output logic [dff_pkg::COL_W-1:0]   column,
    output logic [dff_pkg::ROW_W-1:0]   row_out,
    output logic                        invert_out,
    output logic                        drawn,
    output logic                        last
);
    import dff_pkg::*;

    dab_t   dab_data  [DAB_STAGES+1];
    logic   dab_valid [DAB_STAGES+1];
    logic   dab_ready [DAB_STAGES+1];
    field_t fmt_field;
    logic   fmt_valid;
    logic   fmt_ready;

    dff_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .value     (value),
        .row       (row),
        .start_col (start_col),
        .invert    (invert),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (dab_data[0]),
        .out_valid (dab_valid[0]),
        .out_ready (dab_ready[0])
    );

    for (genvar g = 0; g < DAB_STAGES; g++)
    begin : g_dab
        dff_dab u_dab (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_data   (dab_data[g]),
            .in_valid  (dab_valid[g]),
            .in_ready  (dab_ready[g]),
            .out_data  (dab_data[g+1]),
            .out_valid (dab_valid[g+1]),
            .out_ready (dab_ready[g+1])
        );
    end

    dff_fmt u_fmt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (dab_data[DAB_STAGES]),
        .in_valid  (dab_valid[DAB_STAGES]),
        .in_ready  (dab_ready[DAB_STAGES]),
        .out_field (fmt_field),
        .out_valid (fmt_valid),
        .out_ready (fmt_ready)
    );

    dff_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_field   (fmt_field),
        .in_valid   (fmt_valid),
        .in_ready   (fmt_ready),
        .char_code  (char_code),
        .column     (column),
        .row_out    (row_out),
        .invert_out (invert_out),
        .drawn      (drawn),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

[src/dff_mag.sv]
`timescale 1ns / 1ps

module dff_mag (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dff_pkg::MODE_W-1:0]   mode,
    input  logic [dff_pkg::VALUE_W-1:0]  value,
    input  logic [dff_pkg::ROW_W-1:0]    row,
    input  logic [dff_pkg::COL_W-1:0]    start_col,
    input  logic                         invert,
    input  logic                         in_valid,
    output logic                         in_ready,
    output dff_pkg::dab_t                out_data,
    output logic                         out_valid,
    input  logic                         out_ready
);
    import dff_pkg::*;

    logic               vld_reg;
    dab_t               data_reg;
    dab_t               data_next;
    logic [VALUE_W-1:0] diff;

    always_comb
    begin
        diff                     = '0;
        data_next.bcd            = '0;
        data_next.bin            = value;
        data_next.side.mode      = mode;
        data_next.side.sign_char = CH_SPACE;
        data_next.side.row       = row;
        data_next.side.col       = start_col;
        data_next.side.inv       = invert;
        case (mode)
            MODE_ANGLE:
            begin
                if (value < ANGLE_CENTER)
                begin
                    diff                     = ANGLE_CENTER - value;
                    data_next.side.sign_char = CH_MINUS;
                end
                else
                begin
                    diff                     = value - ANGLE_CENTER;
                    data_next.side.sign_char = (diff[7:0] == 8'd0) ? CH_SPACE : CH_PLUS;
                end
                data_next.bin = VALUE_W'(diff[7:0]);
            end
            MODE_OFFSET:
            begin
                if (value < OFFSET_CENTER)
                begin
                    diff                     = OFFSET_CENTER - value;
                    data_next.side.sign_char = CH_PLUS;
                end
                else
                begin
                    diff                     = value - OFFSET_CENTER;
                    data_next.side.sign_char = (diff == '0) ? CH_SPACE : CH_MINUS;
                end
                data_next.bin = diff;
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[src/dff_dab.sv]
`timescale 1ns / 1ps

module dff_dab (
    input  logic          clk,
    input  logic          rst_n,
    input  dff_pkg::dab_t in_data,
    input  logic          in_valid,
    output logic          in_ready,
    output dff_pkg::dab_t out_data,
    output logic          out_valid,
    input  logic          out_ready
);
    import dff_pkg::*;

    logic                          vld_reg;
    dab_t                          data_reg;
    dab_t                          data_next;
    logic [DIGITS*4+VALUE_W-1:0]   sh;

    // shift-and-add-three, a fixed slice of the binary word per stage
    always_comb
    begin
        data_next = in_data;
        sh        = '0;
        for (int s = 0; s < DAB_STEPS; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (data_next.bcd[d] >= 4'd5)
                begin
                    data_next.bcd[d] = data_next.bcd[d] + 4'd3;
                end
            end
            sh = {data_next.bcd, data_next.bin} << 1;
            {data_next.bcd, data_next.bin} = sh;
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[src/dff_fmt.sv]
`timescale 1ns / 1ps

module dff_fmt (
    input  logic            clk,
    input  logic            rst_n,
    input  dff_pkg::dab_t   in_data,
    input  logic            in_valid,
    output logic            in_ready,
    output dff_pkg::field_t out_field,
    output logic            out_valid,
    input  logic            out_ready
);
    import dff_pkg::*;

    logic          vld_reg;
    field_t        fld_reg;
    field_t        fld_next;
    bcd_t          d;
    logic [DIGITS:0] nz;

    function automatic logic [CHAR_W:0] lead(input logic [3:0] dig, input logic nz_here,
                                             input logic nz_above);
        logic [CHAR_W:0] r;
        if (!nz_here)
            r = {1'b1, CH_SPACE};
        else if (nz_above)
            r = {1'b0, CH_SPACE};
        else
            r = {1'b1, CH_ZERO + CHAR_W'(dig)};
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] inner(input logic [3:0] dig, input logic nz_here);
        return nz_here ? CH_ZERO + CHAR_W'(dig) : CH_SPACE;
    endfunction

    function automatic logic [CHAR_W-1:0] digit(input logic [3:0] dig);
        return CH_ZERO + CHAR_W'(dig);
    endfunction

    always_comb
    begin
        d         = in_data.bcd;
        nz[DIGITS] = 1'b0;
        for (int k = DIGITS - 1; k >= 0; k--)
        begin
            nz[k] = nz[k+1] | (d[k] != 4'd0);
        end

        fld_next.code  = {FIELD_MAX{CH_SPACE}};
        fld_next.drawn = '1;
        fld_next.count = '0;
        fld_next.row   = in_data.side.row;
        fld_next.col   = in_data.side.col;
        fld_next.inv   = in_data.side.inv;

        case (in_data.side.mode)
            MODE_DIG2:
            begin
                {fld_next.drawn[0], fld_next.code[0]} = lead(d[1], nz[1], nz[2]);
                fld_next.code[1] = digit(d[0]);
                fld_next.count   = 3'd2;
            end
            MODE_DIG3:
            begin
                {fld_next.drawn[0], fld_next.code[0]} = lead(d[2], nz[2], nz[3]);
                fld_next.code[1] = inner(d[1], nz[1]);
                fld_next.code[2] = digit(d[0]);
                fld_next.count   = 3'd3;
            end
            MODE_DIG4:
            begin
                {fld_next.drawn[0], fld_next.code[0]} = lead(d[3], nz[3], nz[4]);
                fld_next.code[1] = inner(d[2], nz[2]);
                fld_next.code[2] = inner(d[1], nz[1]);
                fld_next.code[3] = digit(d[0]);
                fld_next.count   = 3'd4;
            end
            MODE_DIG5:
            begin
                {fld_next.drawn[0], fld_next.code[0]} = lead(d[4], nz[4], nz[5]);
                fld_next.code[1] = inner(d[3], nz[3]);
                fld_next.code[2] = inner(d[2], nz[2]);
                fld_next.code[3] = inner(d[1], nz[1]);
                fld_next.code[4] = digit(d[0]);
                fld_next.count   = 3'd5;
            end
            MODE_DIG6:
            begin
                {fld_next.drawn[0], fld_next.code[0]} = lead(d[5], nz[5], nz[6]);
                fld_next.code[1] = inner(d[4], nz[4]);
                fld_next.code[2] = inner(d[3], nz[3]);
                fld_next.code[3] = inner(d[2], nz[2]);
                fld_next.code[4] = inner(d[1], nz[1]);
                fld_next.code[5] = digit(d[0]);
                fld_next.count   = 3'd6;
            end
            MODE_ANGLE:
            begin
                fld_next.code[0] = in_data.side.sign_char;
                fld_next.code[1] = inner(d[1], nz[1]);
                fld_next.code[2] = digit(d[0]);
                fld_next.count   = 3'd3;
            end
            MODE_OFFSET:
            begin
                fld_next.code[0] = in_data.side.sign_char;
                {fld_next.drawn[1], fld_next.code[1]} = lead(d[2], nz[2], nz[3]);
                fld_next.code[2] = inner(d[1], nz[1]);
                fld_next.code[3] = digit(d[0]);
                fld_next.count   = 3'd4;
            end
            MODE_DDD_D:
            begin
                {fld_next.drawn[0], fld_next.code[0]} = lead(d[3], nz[3], nz[4]);
                fld_next.code[1] = inner(d[2], nz[2]);
                fld_next.code[2] = digit(d[1]);
                fld_next.code[3] = CH_POINT;
                fld_next.code[4] = digit(d[0]);
                fld_next.count   = 3'd5;
            end
            MODE_DD_D:
            begin
                {fld_next.drawn[0], fld_next.code[0]} = lead(d[2], nz[2], nz[3]);
                fld_next.code[1] = digit(d[1]);
                fld_next.code[2] = CH_POINT;
                fld_next.code[3] = digit(d[0]);
                fld_next.count   = 3'd4;
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_field = fld_reg;

    // drop words of an unused mode here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid && (fld_next.count != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fld_reg <= fld_next;
        end
    end

endmodule

[src/dff_ser.sv]
`timescale 1ns / 1ps

module dff_ser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dff_pkg::field_t             in_field,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic [dff_pkg::CHAR_W-1:0]  char_code,
    output logic [dff_pkg::COL_W-1:0]   column,
    output logic [dff_pkg::ROW_W-1:0]   row_out,
    output logic                        invert_out,
    output logic                        drawn,
    output logic                        last,
    output logic                        out_valid,
    input  logic                        out_ready
);
    import dff_pkg::*;

    field_t             fld_reg;
    logic               fld_valid_reg;
    logic               fld_valid_next;
    logic [POS_W-1:0]   idx_reg;
    logic [POS_W-1:0]   idx_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CHAR_W-1:0]  char_code_reg;
    logic [COL_W-1:0]   column_reg;
    logic [ROW_W-1:0]   row_reg;
    logic               invert_reg;
    logic               drawn_reg;
    logic               last_reg;
    logic               load_out;
    logic               last_now;

    assign load_out = !out_valid_reg || out_ready;
    assign last_now = fld_valid_reg && (idx_reg == fld_reg.count - POS_W'(1));
    assign in_ready = !fld_valid_reg || (load_out && last_now);

    always_comb
    begin
        fld_valid_next = fld_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = fld_valid_reg;
            if (fld_valid_reg)
            begin
                if (last_now)
                begin
                    fld_valid_next = 1'b0;
                    idx_next       = '0;
                end
                else
                begin
                    idx_next = idx_reg + POS_W'(1);
                end
            end
        end
        if (in_valid && in_ready)
        begin
            fld_valid_next = 1'b1;
            idx_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fld_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fld_valid_reg <= fld_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fld_reg <= in_field;
        end
        if (load_out && fld_valid_reg)
        begin
            char_code_reg <= fld_reg.code[idx_reg];
            column_reg    <= fld_reg.col + COL_W'(idx_reg);
            row_reg       <= fld_reg.row;
            invert_reg    <= fld_reg.inv;
            drawn_reg     <= fld_reg.drawn[idx_reg];
            last_reg      <= last_now;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_code  = char_code_reg;
    assign column     = column_reg;
    assign row_out    = row_reg;
    assign invert_out = invert_reg;
    assign drawn      = drawn_reg;
    assign last       = last_reg;

endmodule

[src/dff_checker.sv]
`timescale 1ns / 1ps

module dff_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [dff_pkg::CHAR_W-1:0]  char_code,
    input  logic [dff_pkg::COL_W-1:0]   column,
    input  logic [dff_pkg::ROW_W-1:0]   row_out,
    input  logic                        invert_out,
    input  logic                        drawn,
    input  logic                        last
);
    import dff_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(column)
            && $stable(drawn) && $stable(last))
        else $error("output word changed while stalled");

    // characters of one field follow without a gap, one column apart
    a_field_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && column == $past(column) + 8'd1
            && row_out == $past(row_out) && invert_out == $past(invert_out))
        else $error("field characters broken or columns not consecutive");

    a_undrawn_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !drawn |-> char_code == CH_SPACE)
        else $error("undrawn column carries a non-space code");

    a_point_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_code == CH_POINT |-> !last)
        else $error("decimal point ends a field");

endmodule

bind decimal_field_formatter dff_checker u_checker (.*);

[tb/field_char_checker.sv]
`timescale 1ns / 1ps

module field_char_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [dff_pkg::MODE_W-1:0]  mode,
    input  logic [dff_pkg::VALUE_W-1:0] value,
    input  logic [dff_pkg::ROW_W-1:0]   row,
    input  logic [dff_pkg::COL_W-1:0]   start_col,
    input  logic                        invert,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [dff_pkg::CHAR_W-1:0]  char_code,
    input  logic [dff_pkg::COL_W-1:0]   column,
    input  logic [dff_pkg::ROW_W-1:0]   row_out,
    input  logic                        invert_out,
    input  logic                        drawn,
    input  logic                        last,
    output int                          mismatch_count,
    output int                          chars_outstanding,
    output int                          chars_checked
);

    import dff_pkg::*;

    localparam int unsigned TOP_WEIGHT_6 = 100000;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              inv;
        logic              drawn;
        logic              last;
    } char_word_t;

    char_word_t expected_chars[$];

    function automatic logic [CHAR_W-1:0] digit_char(int unsigned v);
        return CHAR_W'(CH_ZERO + v % 10);
    endfunction

    function automatic logic [CHAR_W-1:0] inner_char(int unsigned v, int unsigned w);
        return (v < w) ? CH_SPACE : digit_char(v / w);
    endfunction

    // {drawn, code} of the leading column
    function automatic logic [CHAR_W:0] lead_char(int unsigned v, int unsigned w);
        int unsigned q;
        q = v / w;
        if (v < w)
            return {1'b1, CH_SPACE};
        if (q > 9)
            return {1'b0, CH_SPACE};
        return {1'b1, CHAR_W'(CH_ZERO + q)};
    endfunction

    task automatic predict_field(
        input logic [MODE_W-1:0]  md,
        input logic [VALUE_W-1:0] val,
        input logic [ROW_W-1:0]   r,
        input logic [COL_W-1:0]   c,
        input logic               inv
    );
        logic [CHAR_W-1:0]    code [FIELD_MAX];
        logic [FIELD_MAX-1:0] shown;
        int unsigned          v;
        int unsigned          mag;
        int                   n;
        char_word_t           w;
        v = val;
        n = 0;
        shown = '1;
        for (int k = 0; k < FIELD_MAX; k++)
            code[k] = CH_SPACE;
        case (md)
            MODE_DIG2:
            begin
                {shown[0], code[0]} = lead_char(v, 10);
                code[1] = digit_char(v);
                n = 2;
            end
            MODE_DIG3:
            begin
                {shown[0], code[0]} = lead_char(v, 100);
                code[1] = inner_char(v, 10);
                code[2] = digit_char(v);
                n = 3;
            end
            MODE_DIG4:
            begin
                {shown[0], code[0]} = lead_char(v, 1000);
                code[1] = inner_char(v, 100);
                code[2] = inner_char(v, 10);
                code[3] = digit_char(v);
                n = 4;
            end
            MODE_DIG5:
            begin
                {shown[0], code[0]} = lead_char(v, 10000);
                code[1] = inner_char(v, 1000);
                code[2] = inner_char(v, 100);
                code[3] = inner_char(v, 10);
                code[4] = digit_char(v);
                n = 5;
            end
            MODE_DIG6:
            begin
                {shown[0], code[0]} = lead_char(v, TOP_WEIGHT_6);
                code[1] = inner_char(v, 10000);
                code[2] = inner_char(v, 1000);
                code[3] = inner_char(v, 100);
                code[4] = inner_char(v, 10);
                code[5] = digit_char(v);
                n = 6;
            end
            MODE_ANGLE:
            begin
                if (v < ANGLE_CENTER)
                begin
                    mag = (ANGLE_CENTER - v) & 'hff;
                    code[0] = CH_MINUS;
                end
                else
                begin
                    mag = (v - ANGLE_CENTER) & 'hff;
                    code[0] = (mag == 0) ? CH_SPACE : CH_PLUS;
                end
                code[1] = inner_char(mag, 10);
                code[2] = digit_char(mag);
                n = 3;
            end
            MODE_OFFSET:
            begin
                if (v < OFFSET_CENTER)
                begin
                    mag = OFFSET_CENTER - v;
                    code[0] = CH_PLUS;
                end
                else
                begin
                    mag = v - OFFSET_CENTER;
                    code[0] = (mag == 0) ? CH_SPACE : CH_MINUS;
                end
                {shown[1], code[1]} = lead_char(mag, 100);
                code[2] = inner_char(mag, 10);
                code[3] = digit_char(mag);
                n = 4;
            end
            MODE_DDD_D:
            begin
                {shown[0], code[0]} = lead_char(v, 1000);
                code[1] = inner_char(v, 100);
                code[2] = digit_char(v / 10);
                code[3] = CH_POINT;
                code[4] = digit_char(v);
                n = 5;
            end
            MODE_DD_D:
            begin
                {shown[0], code[0]} = lead_char(v, 100);
                code[1] = digit_char(v / 10);
                code[2] = CH_POINT;
                code[3] = digit_char(v);
                n = 4;
            end
            default:
                n = 0;
        endcase
        for (int k = 0; k < n; k++)
        begin
            w.code  = code[k];
            w.col   = c + COL_W'(k);
            w.row   = r;
            w.inv   = inv;
            w.drawn = shown[k];
            w.last  = (k == n - 1);
            expected_chars.push_back(w);
        end
    endtask

    function automatic int field_differs(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v == act_v)
            return 0;
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        char_word_t w;
        int         bad;
        int         hit;
        if (!rst_n)
        begin
            mismatch_count    <= 0;
            chars_outstanding <= 0;
            chars_checked     <= 0;
        end
        else
        begin
            bad = 0;
            hit = 0;
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("char_code: expected nothing, got 0x%0h at column %0d",
                           char_code, column);
                    bad = 1;
                end
                else
                begin
                    w = expected_chars.pop_front();
                    bad = field_differs("char_code", w.code, char_code)
                        + field_differs("column", w.col, column)
                        + field_differs("row_out", w.row, row_out)
                        + field_differs("invert_out", w.inv, invert_out)
                        + field_differs("drawn", w.drawn, drawn)
                        + field_differs("last", w.last, last);
                    hit = 1;
                end
            end
            if (in_valid && in_ready)
                predict_field(mode, value, row, start_col, invert);
            mismatch_count    <= mismatch_count + bad;
            chars_checked     <= chars_checked + hit;
            chars_outstanding <= expected_chars.size();
        end
    end

endmodule

[tb/tb_decimal_field_formatter.sv]
`timescale 1ns / 1ps

module tb_decimal_field_formatter;

    import dff_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_FIELDS = 320;

    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = MODE_DD_D + MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = '1;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [MODE_W-1:0]  mode      = '0;
    logic [VALUE_W-1:0] value     = '0;
    logic [ROW_W-1:0]   row       = '0;
    logic [COL_W-1:0]   start_col = '0;
    logic               invert    = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CHAR_W-1:0]  char_code;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row_out;
    logic               invert_out;
    logic               drawn;
    logic               last;

    logic steady       = 1'b0;
    int   fields_sent  = 0;
    int   quiet_cycles = 0;
    int   mismatch_count;
    int   chars_outstanding;
    int   chars_checked;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    decimal_field_formatter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .value      (value),
        .row        (row),
        .start_col  (start_col),
        .invert     (invert),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_code  (char_code),
        .column     (column),
        .row_out    (row_out),
        .invert_out (invert_out),
        .drawn      (drawn),
        .last       (last)
    );

    field_char_checker char_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .value             (value),
        .row               (row),
        .start_col         (start_col),
        .invert            (invert),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .char_code         (char_code),
        .column            (column),
        .row_out           (row_out),
        .invert_out        (invert_out),
        .drawn             (drawn),
        .last              (last),
        .mismatch_count    (mismatch_count),
        .chars_outstanding (chars_outstanding),
        .chars_checked     (chars_checked)
    );

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 34);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb_decimal_field_formatter NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_field(
        input logic [MODE_W-1:0]  md,
        input logic [VALUE_W-1:0] v,
        input logic [ROW_W-1:0]   r,
        input logic [COL_W-1:0]   c,
        input logic               inv
    );
        while (!steady && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= md;
        value     <= v;
        row       <= r;
        start_col <= c;
        invert    <= inv;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        fields_sent++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (chars_outstanding != 0);
        @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value(logic [MODE_W-1:0] md);
        int unsigned span;
        case (md)
            MODE_DIG2:   span = 100;
            MODE_DIG3:   span = 1000;
            MODE_DIG4:   span = 10000;
            MODE_DIG5:   span = 100000;
            MODE_DIG6:   span = 1000000;
            MODE_ANGLE:  span = 200;
            MODE_OFFSET: span = 1000;
            MODE_DDD_D:  span = 10000;
            MODE_DD_D:   span = 1000;
            default:     span = 1000000;
        endcase
        case ($urandom_range(9))
            0, 1:    return VALUE_W'($urandom);
            2:       return VALUE_W'($urandom_range(span + span / 2));
            3:       return (md == MODE_ANGLE) ? VALUE_W'($urandom_range(110, 90))
                                               : VALUE_W'($urandom_range(338, 318));
            default: return VALUE_W'($urandom_range(span - 1));
        endcase
    endfunction

    initial
    begin
        logic [MODE_W-1:0] md;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_field(MODE_DIG2, 0, 0, 0, 1'b0);
        send_field(MODE_DIG2, 9, 1, 10, 1'b1);
        send_field(MODE_DIG2, 100, 2, 20, 1'b0);
        send_field(MODE_DIG3, 999, 3, 40, 1'b1);
        send_field(MODE_DIG4, 1000, 1, 50, 1'b1);
        send_field(MODE_DIG4, 10000, 2, 60, 1'b0);
        send_field(MODE_DIG5, 12345, 3, 70, 1'b1);
        send_field(MODE_DIG6, 999999, 1, 252, 1'b1);
        send_field(MODE_DIG6, 20'hfffff, 2, 255, 1'b0);
        send_field(MODE_DIG6, 100000, 3, 128, 1'b1);
        send_field(MODE_ANGLE, 100, 0, 5, 1'b0);
        send_field(MODE_ANGLE, 0, 1, 6, 1'b1);
        send_field(MODE_ANGLE, 99, 2, 7, 1'b0);
        send_field(MODE_ANGLE, 199, 3, 8, 1'b1);
        send_field(MODE_ANGLE, 450, 0, 254, 1'b0);
        send_field(MODE_OFFSET, 328, 1, 90, 1'b1);
        send_field(MODE_OFFSET, 0, 2, 91, 1'b0);
        send_field(MODE_OFFSET, 329, 3, 92, 1'b1);
        send_field(MODE_OFFSET, 1500, 0, 93, 1'b0);
        send_field(MODE_DDD_D, 9999, 1, 100, 1'b1);
        send_field(MODE_DDD_D, 5, 2, 110, 1'b0);
        send_field(MODE_DD_D, 999, 3, 120, 1'b1);
        send_field(MODE_DD_D, 7, 0, 253, 1'b0);
        send_field(MODE_UNUSED_LO, 20'h5a5a5, 1, 30, 1'b1);
        send_field(MODE_UNUSED_HI, 20'ha5a5a, 2, 31, 1'b0);

        for (int i = 0; i < RANDOM_FIELDS; i++)
        begin
            steady <= (i >= 100 && i < 180);
            if (i == 160)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            if ($urandom_range(19) == 0)
                md = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
            else
                md = MODE_W'($urandom_range(MODE_DD_D, MODE_DIG2));
            send_field(md, random_value(md), ROW_W'($urandom_range(3)),
                       ($urandom_range(3) == 0) ? COL_W'($urandom_range(255, 250))
                                                : COL_W'($urandom_range(255)),
                       1'($urandom_range(1)));
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Fed %0d fields over every format, unused modes and wrapping columns;",
                 fields_sent);
        $display("compared %0d character words, %0d field mismatches.",
                 chars_checked, mismatch_count);
        if (mismatch_count == 0 && chars_outstanding == 0)
            $display("tb_decimal_field_formatter OK");
        else
            $display("tb_decimal_field_formatter NOT OK");
        $finish;
    end

endmodule
